### hw/rtl/ppm_fe_pkg.sv
`default_nettype none

package ppm_fe_pkg;

   // Frame timing and channel limits
   localparam int SETUP_TIME_US = 500;
   localparam int MAX_CHANNELS  = 16;

   // Job queue geometry
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PPM_MODE        = 3'd0;
   localparam logic [2:0] REG_EXTENDED_LIMITS = 3'd1;
   localparam logic [2:0] REG_SYNC_DELAY      = 3'd2;
   localparam logic [2:0] REG_FRAME_LENGTH    = 3'd3;
   localparam logic [2:0] REG_CHANNEL_SETTING = 3'd4;

   // Output modes
   localparam logic [1:0] MODE_PPM   = 2'd0;
   localparam logic [1:0] MODE_SIM   = 2'd1;
   localparam logic [1:0] MODE_16_LO = 2'd2;
   localparam logic [1:0] MODE_16_HI = 2'd3;

   // Arithmetic constants in half-microsecond ticks
   localparam logic signed [13:0] CLAMP_NORMAL = 14'sd1024;
   localparam logic signed [13:0] CLAMP_EXT    = 14'sd1280;
   localparam logic signed [19:0] FRAME_TICKS  = 20'sd45000;
   localparam logic signed [19:0] REST_MIN     = 20'sd9000;
   localparam logic signed [19:0] REST_MAX     = 20'sd65535;
   localparam logic [15:0]        SETUP_TICKS  = 16'(2 * SETUP_TIME_US);

   // Configuration register file contents
   typedef struct packed {
      logic [1:0] ppm_mode;
      logic       extended_limits;
      logic [4:0] sync_delay;
      logic [6:0] frame_length;
      logic [2:0] channel_setting;
   } cfg_type;

   // One classified channel, waiting for the output side
   typedef struct packed {
      logic [15:0]        sync_word;
      logic [15:0]        chan_word;
      logic signed [19:0] rest;
      logic               half;
      logic               last;
   } job_type;

endpackage

`default_nettype wire

### hw/rtl/ppm_fe_csr.sv
`default_nettype none

module ppm_fe_csr
   import ppm_fe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Update the addressed register on the access cycle
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_PPM_MODE:        cfg_in.ppm_mode        = pwdata[1:0];
            REG_EXTENDED_LIMITS: cfg_in.extended_limits = pwdata[0];
            REG_SYNC_DELAY:      cfg_in.sync_delay      = pwdata[4:0];
            REG_FRAME_LENGTH:    cfg_in.frame_length    = pwdata[6:0];
            REG_CHANNEL_SETTING: cfg_in.channel_setting = pwdata[2:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ppm_mode        <= MODE_PPM;
         cfg_ff.extended_limits <= 1'b0;
         cfg_ff.sync_delay      <= 5'd0;
         cfg_ff.frame_length    <= 7'd0;
         cfg_ff.channel_setting <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_index)
         REG_PPM_MODE:        prdata = {30'd0, cfg_ff.ppm_mode};
         REG_EXTENDED_LIMITS: prdata = {31'd0, cfg_ff.extended_limits};
         REG_SYNC_DELAY:      prdata = {27'd0, cfg_ff.sync_delay};
         REG_FRAME_LENGTH:    prdata = {25'd0, cfg_ff.frame_length};
         REG_CHANNEL_SETTING: prdata = {29'd0, cfg_ff.channel_setting};
         default:             prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/ppm_fe_front.sv
`default_nettype none

module ppm_fe_front
   import ppm_fe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [11:0] req_channel_value,
   input  wire logic        [10:0] req_channel_center,
   input  wire logic               q_full,
   output logic                    push,
   output job_type                 push_job
);

   logic [4:0]         counter_ff;
   logic [4:0]         counter_in;
   logic signed [19:0] rest_ff;
   logic signed [19:0] rest_in;

   logic               short_mode;
   logic signed [15:0] sync_ext;
   logic [15:0]        sync_w;
   logic signed [19:0] frame_ext;
   logic signed [19:0] frame_start;
   logic signed [13:0] range;
   logic signed [13:0] val_ext;
   logic signed [13:0] val_clamped;
   logic signed [13:0] width_v;
   logic signed [19:0] rest_base;
   logic signed [19:0] rest_new;
   logic [5:0]         count_raw;
   logic [4:0]         frame_count;
   logic [4:0]         counter_next;
   logic               last;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   // Sync width and frame start from the current registers
   assign short_mode  = (cfg.ppm_mode == MODE_PPM) || (cfg.ppm_mode == MODE_SIM);
   assign sync_ext    = $signed({{11{cfg.sync_delay[4]}}, cfg.sync_delay});
   assign sync_w      = 16'(sync_ext * 16'sd100 + 16'sd600);
   assign frame_ext   = $signed({{13{cfg.frame_length[6]}}, cfg.frame_length}) * 20'sd1000;
   assign frame_start = FRAME_TICKS - $signed({4'd0, sync_w})
                        + (short_mode ? frame_ext : 20'sd0);

   // Clamp the channel value and add twice the centre
   assign range   = cfg.extended_limits ? CLAMP_EXT : CLAMP_NORMAL;
   assign val_ext = 14'(req_channel_value);
   always_comb begin
      priority if (val_ext > range) val_clamped = range;
      else if (val_ext < -range)    val_clamped = -range;
      else                          val_clamped = val_ext;
   end
   assign width_v = val_clamped + $signed({2'd0, req_channel_center, 1'b0});

   // Reload the rest at a frame's first channel
   assign rest_base = (counter_ff == 5'd0) ? frame_start : rest_ff;
   assign rest_new  = rest_base - 20'(width_v);

   // Channels in this frame
   assign count_raw = 6'd4 + {2'd0, cfg.channel_setting, 1'b0};
   always_comb begin
      if (short_mode) begin
         frame_count = (count_raw > 6'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : count_raw[4:0];
      end else begin
         frame_count = 5'(MAX_CHANNELS / 2);
      end
   end
   assign counter_next = counter_ff + 5'd1;
   assign last         = counter_next >= frame_count;

   // Build the job for the output side
   always_comb begin
      push_job.sync_word = sync_w;
      push_job.chan_word = 16'(width_v) - sync_w;
      push_job.rest      = rest_new;
      push_job.half      = (cfg.ppm_mode == MODE_SIM) || (cfg.ppm_mode == MODE_16_HI);
      push_job.last      = last;
   end

   // Advance frame state on each transfer
   always_comb begin
      counter_in = counter_ff;
      rest_in    = rest_ff;
      if (push) begin
         counter_in = last ? 5'd0 : counter_next;
         rest_in    = rest_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 5'd0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ppm_fe_queue.sv
`default_nettype none

module ppm_fe_queue
   import ppm_fe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head
);

   job_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_in;
   logic [Q_AW:0]   fill_ff;
   logic [Q_AW:0]   fill_in;

   assign full       = fill_ff == (Q_AW+1)'(Q_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ppm_fe_back.sv
`default_nettype none

module ppm_fe_back
   import ppm_fe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [15:0]  rsp_pulse_width,
   output logic         rsp_second_half,
   output logic         rsp_end_of_frame
);

   typedef enum logic [2:0] {
      W_SYNC,
      W_CHAN,
      W_TAIL_SYNC,
      W_REST,
      W_EOF
   } word_type;

   word_type    word_ff;
   word_type    word_in;
   logic        valid_ff;
   logic        valid_in;
   logic [15:0] width_ff;
   logic [15:0] width_in;
   logic        half_ff;
   logic        half_in;
   logic        eof_ff;
   logic        eof_in;

   logic        advance;
   logic        load;
   logic [15:0] rest_clamped;

   assign advance = !valid_ff || rsp_ready;
   assign load    = advance && head_valid;
   assign pop     = load && (((word_ff == W_CHAN) && !head.last) || (word_ff == W_EOF));

   // Clamp the frame rest to the legal gap range
   always_comb begin
      priority if (head.rest > REST_MAX) rest_clamped = REST_MAX[15:0];
      else if (head.rest < REST_MIN)     rest_clamped = REST_MIN[15:0];
      else                               rest_clamped = head.rest[15:0];
   end

   // Select the next word and step through the job
   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      width_in = width_ff;
      half_in  = half_ff;
      eof_in   = eof_ff;
      if (load) begin
         valid_in = 1'b1;
         half_in  = head.half;
         eof_in   = 1'b0;
         unique case (word_ff)
            W_SYNC: begin
               width_in = head.sync_word;
               word_in  = W_CHAN;
            end
            W_CHAN: begin
               width_in = head.chan_word;
               word_in  = head.last ? W_TAIL_SYNC : W_SYNC;
            end
            W_TAIL_SYNC: begin
               width_in = head.sync_word;
               word_in  = W_REST;
            end
            W_REST: begin
               width_in = rest_clamped - SETUP_TICKS;
               word_in  = W_EOF;
            end
            W_EOF: begin
               width_in = 16'd0;
               eof_in   = 1'b1;
               word_in  = W_SYNC;
            end
            default: word_in = W_SYNC;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= W_SYNC;
         valid_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         valid_ff <= valid_in;
         width_ff <= width_in;
         half_ff  <= half_in;
         eof_ff   <= eof_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pulse_width  = width_ff;
   assign rsp_second_half  = half_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule

`default_nettype wire

### hw/rtl/ppm_frame_encoder.sv
// Path: a channel's job enters the job queue on its transfer, and its first word is then
//    loaded from the queue head into the output register that drives rsp.
// Output: the output register sends one word per cycle while rsp_ready is high, and a
//    four-entry job queue lets input run ahead of it.
// Reset: synchronous, active high; clears the queue, the channel counter and rsp_valid,
//    and loads the register defaults; the frame rest is reloaded at the first channel.
`default_nettype none

module ppm_frame_encoder
   import ppm_fe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [11:0] req_channel_value,
   input  wire logic        [10:0] req_channel_center,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [15:0] rsp_pulse_width,
   output logic                    rsp_second_half,
   output logic                    rsp_end_of_frame,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic        [4:0]  paddr,
   input  wire logic        [31:0] pwdata,
   output logic             [31:0] prdata,
   output logic                    pready
);

   cfg_type cfg;
   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head;

   ppm_fe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ppm_fe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_value  (req_channel_value),
      .req_channel_center (req_channel_center),
      .q_full             (q_full),
      .push               (push),
      .push_job           (push_job)
   );

   ppm_fe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   ppm_fe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_width  (rsp_pulse_width),
      .rsp_second_half  (rsp_second_half),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

### hw/rtl/ppm_fe_chk.sv
`default_nettype none

module ppm_fe_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pulse_width,
   input wire logic        rsp_second_half,
   input wire logic        rsp_end_of_frame,
   input wire logic        pready
);

   // Drop any pending word on reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_width)
         && $stable(rsp_end_of_frame) && $stable(rsp_second_half))
      else $error("stalled rsp word changed");

   // End of frame carries the terminating zero
   a_eof_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_pulse_width == 16'd0)
      else $error("end of frame word not zero");

   // Consecutive frame ends cannot occur
   a_eof_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_frame |=> !(rsp_valid && rsp_end_of_frame))
      else $error("back to back end of frame words");

   // Configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind ppm_frame_encoder ppm_fe_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pulse_width  (rsp_pulse_width),
   .rsp_second_half  (rsp_second_half),
   .rsp_end_of_frame (rsp_end_of_frame),
   .pready           (pready)
);

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
   import ppm_fe_pkg::*;

   // One PPM width word as it leaves the encoder
   typedef struct packed {
      logic [15:0] width;
      logic        half;
      logic        eof;
   } ppm_word_type;

   // Frame builder mirror: tracks settings, channel count and frame rest,
   // and holds the words still owed by the encoder in arrival order.
   class ppm_frame_scoreboard;
      logic [1:0]   mode;
      logic         ext_limits;
      int           sync_set;
      int           frame_set;
      int           chan_set;
      bit [4:0]     done_channels;
      int           rest_ticks;
      ppm_word_type pending_words[$];
      int           errors;
      int           words_checked;
      int           frames_closed;
      int           channels_seen;

      function new();
         mode = MODE_PPM;
         ext_limits = 1'b0;
         sync_set = 0;
         frame_set = 0;
         chan_set = 2;
         done_channels = '0;
         errors = 0;
         words_checked = 0;
         frames_closed = 0;
         channels_seen = 0;
         rest_ticks = frame_rest_start();
      endfunction

      function logic [15:0] sync_ticks();
         return 16'((sync_set * 50 + 300) * 2);
      endfunction

      function int frame_rest_start();
         int r;
         r = 45000 - int'(sync_ticks());
         if (mode <= MODE_SIM) begin
            r += frame_set * 1000;
         end
         return r;
      endfunction

      function int channels_per_frame();
         int n;
         if (mode <= MODE_SIM) begin
            n = 4 + 2 * chan_set;
            if (n > MAX_CHANNELS) begin
               n = MAX_CHANNELS;
            end
         end else begin
            n = MAX_CHANNELS / 2;
         end
         return n;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_PPM_MODE: begin
               mode = value[1:0];
            end
            REG_EXTENDED_LIMITS: begin
               ext_limits = value[0];
            end
            REG_SYNC_DELAY: begin
               sync_set = $signed(value[4:0]);
            end
            REG_FRAME_LENGTH: begin
               frame_set = $signed(value[6:0]);
            end
            REG_CHANNEL_SETTING: begin
               chan_set = int'(value[2:0]);
            end
            default: begin
            end
         endcase
      endfunction

      function void push_word(logic [15:0] width, logic half, logic eof);
         pending_words.push_back({width, half, eof});
      endfunction

      // Work out the words one accepted channel transfer produces
      function void note_channel(logic signed [11:0] value, logic [10:0] center);
         int          limit;
         int          v;
         int          r;
         logic [15:0] q;
         logic        half;
         limit = ext_limits ? 1280 : 1024;
         q = sync_ticks();
         half = (mode == MODE_SIM) || (mode == MODE_16_HI);
         channels_seen++;

         // reload the frame rest at the first channel of a frame
         if (done_channels == 0) begin
            rest_ticks = frame_rest_start();
         end

         v = value;
         if (v > limit) begin
            v = limit;
         end
         if (v < -limit) begin
            v = -limit;
         end
         v = v + 2 * int'(center);
         rest_ticks -= v;
         push_word(q, half, 1'b0);
         push_word(16'(v - int'(q)), half, 1'b0);

         // close the frame once the count is reached, also when it shrank
         done_channels = done_channels + 1'b1;
         if (done_channels >= channels_per_frame()) begin
            r = rest_ticks;
            if (r > 65535) begin
               r = 65535;
            end
            if (r < 9000) begin
               r = 9000;
            end
            push_word(q, half, 1'b0);
            push_word(16'(r - 2 * SETUP_TIME_US), half, 1'b0);
            push_word(16'd0, half, 1'b1);
            done_channels = '0;
            rest_ticks = frame_rest_start();
            frames_closed++;
         end
      endfunction

      // Compare one result transfer against the oldest owed word
      function void check_word(logic [15:0] width, logic half, logic eof);
         ppm_word_type owed;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word width=%0d half=%0d eof=%0d",
                     $time, width, half, eof);
            errors++;
            return;
         end
         owed = pending_words.pop_front();
         words_checked++;
         if (width !== owed.width) begin
            $display("%0t: pulse_width mismatch, expected %0d, got %0d",
                     $time, owed.width, width);
            errors++;
         end
         if (half !== owed.half) begin
            $display("%0t: second_half mismatch, expected %0d, got %0d",
                     $time, owed.half, half);
            errors++;
         end
         if (eof !== owed.eof) begin
            $display("%0t: end_of_frame mismatch, expected %0d, got %0d",
                     $time, owed.eof, eof);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [11:0] req_channel_value = '0;
   logic        [10:0] req_channel_center = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [15:0] rsp_pulse_width;
   logic               rsp_second_half;
   logic               rsp_end_of_frame;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic        [4:0]  paddr = '0;
   logic        [31:0] pwdata = '0;
   logic        [31:0] prdata;
   logic               pready;

   int idle_pct = 0;
   int stall_pct = 0;

   ppm_frame_scoreboard sb = new();

   ppm_frame_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_value  (req_channel_value),
      .req_channel_center (req_channel_center),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pulse_width    (rsp_pulse_width),
      .rsp_second_half    (rsp_second_half),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check each result transfer, then draw the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word(rsp_pulse_width, rsp_second_half, rsp_end_of_frame);
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Hold a channel on the input until it transfers, after a random gap
   task automatic send_channel(input int value, input int center);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel_value <= 12'(value);
      req_channel_center <= 11'(center);
      do @(posedge clock); while (!req_ready);
      sb.note_channel(12'(value), 11'(center));
   endtask

   // Drop valid and wait until every owed word has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Register write: setup phase, access phase, then back to idle
   task automatic write_reg(input logic [2:0] idx, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, 32'(value));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int mode, input int ext, input int sync,
                            input int frame_len, input int chans);
      write_reg(REG_PPM_MODE, mode);
      write_reg(REG_EXTENDED_LIMITS, ext);
      write_reg(REG_SYNC_DELAY, sync);
      write_reg(REG_FRAME_LENGTH, frame_len);
      write_reg(REG_CHANNEL_SETTING, chans);
   endtask

   initial begin
      int phase;
      int n;
      int value;
      int center;
      int limit;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes and clamping, four-channel frames
      configure(MODE_PPM, 0, 0, 0, 0);
      send_channel(-2048, 0);
      send_channel(2047, 2047);
      send_channel(-1025, 1500);
      send_channel(1024, 1000);
      wait_drained();

      // Extended limits
      write_reg(REG_EXTENDED_LIMITS, 1);
      send_channel(-1281, 1);
      send_channel(1281, 2046);
      send_channel(1280, 1500);
      send_channel(-1280, 0);
      wait_drained();

      // Negative sync step, long frame: rest clamps high, negative words wrap
      configure(MODE_SIM, 1, -4, 40, 0);
      repeat (4) send_channel(-1024, 0);
      wait_drained();

      // Short frame with wide pulses: rest clamps low; then shrink the count
      configure(MODE_PPM, 1, 10, -20, 6);
      repeat (5) send_channel(2047, 2047);
      wait_drained();
      write_reg(REG_CHANNEL_SETTING, 0);
      send_channel(0, 1500);
      wait_drained();

      // Switch buffer half in the middle of an eight-channel frame
      configure(MODE_16_LO, 0, 3, 5, 1);
      repeat (3) send_channel(100, 1500);
      wait_drained();
      write_reg(REG_PPM_MODE, MODE_16_HI);
      repeat (5) send_channel(-300, 1200);
      wait_drained();

      // Random channels over changing settings and flow-control profiles
      for (phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            configure(MODE_PPM, 0, -4, -20, 0);
         end else if (phase == 1) begin
            configure(MODE_16_HI, 1, 10, 40, 6);
         end else begin
            configure(int'($urandom_range(0, 3)), int'($urandom_range(0, 1)),
                      int'($urandom_range(0, 14)) - 4,
                      int'($urandom_range(0, 60)) - 20,
                      int'($urandom_range(0, 6)));
         end
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 52;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 52;
            end
            default: begin
               idle_pct = 18;
               stall_pct = 18;
            end
         endcase
         for (n = 0; n < 36; n++) begin
            case ($urandom_range(0, 3))
               0: begin
                  value = int'($urandom_range(0, 4095)) - 2048;
               end
               1: begin
                  limit = $urandom_range(0, 1) ? 1280 : 1024;
                  value = limit + int'($urandom_range(0, 4)) - 2;
                  if ($urandom_range(0, 1)) begin
                     value = -value;
                  end
               end
               default: begin
                  value = int'($urandom_range(0, 2600)) - 1300;
               end
            endcase
            if ($urandom_range(0, 3) == 0) begin
               center = int'($urandom_range(0, 2047));
            end else begin
               center = int'($urandom_range(800, 1700));
            end
            send_channel(value, center);
         end
         wait_drained();
      end

      idle_pct = 0;
      stall_pct = 0;
      repeat (16) @(posedge clock);

      $display("Sent %0d channels, closed %0d frames, checked %0d words",
               sb.channels_seen, sb.frames_closed, sb.words_checked);
      $display("All four modes, both clamp ranges and the setting extremes were used");
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
